// File: design/nrlp_pkg.sv
// Package for the number range list parser.
// Holds value widths, character codes, error codes, the parser phase type and
// the state and result structs. Depends on nothing.
package nrlp_pkg;

    localparam int VALUE_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int POS_BITS   = 16;
    localparam int CODE_BITS  = 3;
    localparam int CHAR_BITS  = 8;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_MAX   = '1;

    localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;

    localparam logic [CODE_BITS-1:0] ERR_OK          = 3'd0;
    localparam logic [CODE_BITS-1:0] ERR_NEED_DIGIT  = 3'd1;
    localparam logic [CODE_BITS-1:0] ERR_BAD_NUMBER  = 3'd2;
    localparam logic [CODE_BITS-1:0] ERR_SECOND_DASH = 3'd3;
    localparam logic [CODE_BITS-1:0] ERR_BAD_INTERVAL = 3'd4;

    typedef enum logic [4:0] {
        PH_BEGIN_NUMBER   = 5'b00001,
        PH_NUMBER         = 5'b00010,
        PH_BEGIN_INTERVAL = 5'b00100,
        PH_INTERVAL       = 5'b01000,
        PH_HALTED         = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [VALUE_BITS-1:0] acc;
        logic [VALUE_BITS-1:0] start;
        logic [POS_BITS-1:0]   pos;
    } t_parse_state;

    typedef struct packed {
        logic [OUT_BITS-1:0]  range_low;
        logic [OUT_BITS-1:0]  range_high;
        logic [CODE_BITS-1:0] error_code;
        logic [POS_BITS-1:0]  error_position;
    } t_result;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+OUT_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, v};
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

// File: design/number_range_list_parser.sv
// Top level of the number range list parser: parse state registers, step
// logic and the result register. Depends on nrlp_pkg and nrlp_step.
//
//   channel   valid        ready        payload
//   input     i_in_valid   o_in_ready   i_char_code
//   output    o_out_valid  i_out_ready  o_range_low, o_range_high,
//                                       o_error_code, o_error_position
//
// One character per cycle; a result appears in the cycle after the word that
// closes an entry or raises an error. The only limit is the result register:
// input stalls only while a result sits there and the output is stalled.
// Synchronous active-low reset returns to the start of a number, counters
// cleared. After an error record every word is taken and dropped until reset.
module number_range_list_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [nrlp_pkg::CHAR_BITS-1:0]    i_char_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [nrlp_pkg::OUT_BITS-1:0]     o_range_low,
    output logic [nrlp_pkg::OUT_BITS-1:0]     o_range_high,
    output logic [nrlp_pkg::CODE_BITS-1:0]    o_error_code,
    output logic [nrlp_pkg::POS_BITS-1:0]     o_error_position
);

    nrlp_pkg::t_parse_state r_state;
    nrlp_pkg::t_parse_state n_state;
    nrlp_pkg::t_result      r_out;
    nrlp_pkg::t_result      n_out;
    logic                   r_out_valid;
    logic                   step_emit;
    logic                   in_fire;

    nrlp_step u_step (
        .i_state  (r_state),
        .i_char   (i_char_code),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_out)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= nrlp_pkg::PH_BEGIN_NUMBER;
            r_state.acc   <= '0;
            r_state.start <= '0;
            r_state.pos   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= step_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && step_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_range_low      = r_out.range_low;
    assign o_range_high     = r_out.range_high;
    assign o_error_code     = r_out.error_code;
    assign o_error_position = r_out.error_position;

endmodule

// File: design/nrlp_step.sv
// Per-character next-state and result logic of the range list parser.
// Pure combinational; depends on nrlp_pkg.
module nrlp_step (
    input  nrlp_pkg::t_parse_state            i_state,
    input  logic [nrlp_pkg::CHAR_BITS-1:0]    i_char,
    output nrlp_pkg::t_parse_state            o_state,
    output logic                              o_emit,
    output nrlp_pkg::t_result                 o_result
);

    logic                               is_digit;
    logic                               is_term;
    logic                               is_eol;
    logic [nrlp_pkg::CHAR_BITS-1:0]     digit;
    logic [nrlp_pkg::VALUE_BITS+3:0]    acc_ext;
    logic [nrlp_pkg::VALUE_BITS+3:0]    acc_x10;
    logic [nrlp_pkg::VALUE_BITS-1:0]    acc_push;
    logic [nrlp_pkg::VALUE_BITS-1:0]    digit_val;
    logic [nrlp_pkg::POS_BITS-1:0]      pos_next;

    assign is_eol   = (i_char == nrlp_pkg::CH_NEWLINE) || (i_char == nrlp_pkg::CH_NUL);
    assign is_term  = is_eol || (i_char == nrlp_pkg::CH_COMMA);
    assign is_digit = (i_char >= nrlp_pkg::CH_ZERO) && (i_char <= nrlp_pkg::CH_NINE);
    assign digit    = i_char - nrlp_pkg::CH_ZERO;

    // digit is 0..9 here, 4 bits suffice
    assign digit_val = nrlp_pkg::VALUE_BITS'(digit[3:0]);
    assign acc_ext   = {4'b0000, i_state.acc};
    assign acc_x10   = (acc_ext << 3) + (acc_ext << 1) + {{nrlp_pkg::VALUE_BITS{1'b0}}, digit[3:0]};
    assign acc_push  = (acc_x10[nrlp_pkg::VALUE_BITS+3:nrlp_pkg::VALUE_BITS] != 4'b0000)
                     ? nrlp_pkg::VALUE_MAX : acc_x10[nrlp_pkg::VALUE_BITS-1:0];

    assign pos_next = (!is_eol && (i_state.pos != nrlp_pkg::POS_MAX))
                    ? i_state.pos + 1'b1 : i_state.pos;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_state.phase != nrlp_pkg::PH_HALTED) begin
            o_state.pos = pos_next;
        end
        o_result.error_position = pos_next;
        unique case (i_state.phase)
            nrlp_pkg::PH_BEGIN_NUMBER: begin
                if (is_digit) begin
                    o_state.acc   = digit_val;
                    o_state.phase = nrlp_pkg::PH_NUMBER;
                end else if (!is_eol) begin
                    o_emit                = 1'b1;
                    o_result.error_code   = nrlp_pkg::ERR_NEED_DIGIT;
                    o_state.phase         = nrlp_pkg::PH_HALTED;
                end
            end
            nrlp_pkg::PH_NUMBER: begin
                if (is_digit) begin
                    o_state.acc = acc_push;
                end else if (is_term) begin
                    o_emit                  = 1'b1;
                    o_result.range_low      = nrlp_pkg::to_out(i_state.acc);
                    o_result.range_high     = nrlp_pkg::to_out(i_state.acc);
                    o_result.error_position = '0;
                    o_state.phase           = nrlp_pkg::PH_BEGIN_NUMBER;
                end else if (i_char == nrlp_pkg::CH_DASH) begin
                    o_state.start = i_state.acc;
                    o_state.phase = nrlp_pkg::PH_BEGIN_INTERVAL;
                end else begin
                    o_emit              = 1'b1;
                    o_result.error_code = nrlp_pkg::ERR_BAD_NUMBER;
                    o_state.phase       = nrlp_pkg::PH_HALTED;
                end
            end
            nrlp_pkg::PH_BEGIN_INTERVAL: begin
                if (is_digit) begin
                    o_state.acc   = digit_val;
                    o_state.phase = nrlp_pkg::PH_INTERVAL;
                end else begin
                    o_emit              = 1'b1;
                    o_result.error_code = nrlp_pkg::ERR_NEED_DIGIT;
                    o_state.phase       = nrlp_pkg::PH_HALTED;
                end
            end
            nrlp_pkg::PH_INTERVAL: begin
                if (is_digit) begin
                    o_state.acc = acc_push;
                end else if (is_term) begin
                    o_emit                  = 1'b1;
                    o_result.range_low      = nrlp_pkg::to_out(i_state.start);
                    o_result.range_high     = nrlp_pkg::to_out(i_state.acc);
                    o_result.error_position = '0;
                    o_state.phase           = nrlp_pkg::PH_BEGIN_NUMBER;
                end else begin
                    o_emit              = 1'b1;
                    o_result.error_code = (i_char == nrlp_pkg::CH_DASH)
                                        ? nrlp_pkg::ERR_SECOND_DASH
                                        : nrlp_pkg::ERR_BAD_INTERVAL;
                    o_state.phase       = nrlp_pkg::PH_HALTED;
                end
            end
            nrlp_pkg::PH_HALTED: begin
                o_state = i_state;
            end
            default: begin
                o_state.phase = nrlp_pkg::PH_HALTED;
            end
        endcase
    end

endmodule

// File: design/nrlp_checker.sv
// Port-level checks for the number range list parser, bound to the top level.
// Depends on nrlp_pkg and number_range_list_parser.
module nrlp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [nrlp_pkg::CHAR_BITS-1:0]    i_char_code,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [nrlp_pkg::OUT_BITS-1:0]     o_range_low,
    input logic [nrlp_pkg::OUT_BITS-1:0]     o_range_high,
    input logic [nrlp_pkg::CODE_BITS-1:0]    o_error_code,
    input logic [nrlp_pkg::POS_BITS-1:0]     o_error_position
);

    logic in_digit;
    assign in_digit = (i_char_code >= nrlp_pkg::CH_ZERO) && (i_char_code <= nrlp_pkg::CH_NINE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_range_low)
            && $stable(o_range_high) && $stable(o_error_code) && $stable(o_error_position))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_halt_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_error_code != nrlp_pkg::ERR_OK) |=> !o_out_valid)
        else $error("result after error record");

    a_digit_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && in_digit && !(o_out_valid && !i_out_ready)
            |=> !o_out_valid)
        else $error("digit produced a result");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != nrlp_pkg::ERR_OK)
            |-> (o_range_low == '0) && (o_range_high == '0) && (o_error_position != '0))
        else $error("malformed error record");

endmodule

bind number_range_list_parser nrlp_checker u_nrlp_checker (.*);

// File: tb/sv/nrlp_range_checker.sv
// Checker for the number range list parser: watches both channels, predicts
// the range and error records from the accepted words and compares them.
// Depends on nrlp_pkg.
module nrlp_range_checker
    import nrlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [CHAR_BITS-1:0] i_char_code,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_BITS-1:0]  i_range_low,
    input  logic [OUT_BITS-1:0]  i_range_high,
    input  logic [CODE_BITS-1:0] i_error_code,
    input  logic [POS_BITS-1:0]  i_error_position,
    output int                   o_fail_count,
    output int                   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase                phase;
    logic [VALUE_BITS-1:0] acc;
    logic [VALUE_BITS-1:0] start;
    logic [POS_BITS-1:0]   pos;
    t_result               pending_records[$];
    int                    fails;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fails++;
        if (fails <= 40) begin
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // decimal shift, saturating at the accumulator width
    function automatic logic [VALUE_BITS-1:0] decimal_shift(
        input logic [VALUE_BITS-1:0] a, input logic [CHAR_BITS-1:0] c);
        logic [VALUE_BITS+3:0] wide;
        wide = (VALUE_BITS+4)'(a * 10 + (c - CH_ZERO));
        if (wide > (VALUE_BITS+4)'(VALUE_MAX)) begin
            return VALUE_MAX;
        end
        return wide[VALUE_BITS-1:0];
    endfunction

    task automatic parse_word(input logic [CHAR_BITS-1:0] c);
        t_result rec;
        logic    digit;
        logic    term;
        logic    emit;
        if (phase == PH_HALTED) begin
            return;
        end
        if (c != CH_NEWLINE && c != CH_NUL && pos != POS_MAX) begin
            pos++;
        end
        rec   = '0;
        emit  = 1'b0;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        term  = (c == CH_COMMA) || (c == CH_NEWLINE) || (c == CH_NUL);
        case (phase)
            PH_BEGIN_NUMBER: begin
                if (digit) begin
                    acc   = VALUE_BITS'(c - CH_ZERO);
                    phase = PH_NUMBER;
                end else if (c != CH_NEWLINE && c != CH_NUL) begin
                    rec.error_code = ERR_NEED_DIGIT;
                    emit = 1'b1;
                end
            end
            PH_NUMBER: begin
                if (digit) begin
                    acc = decimal_shift(acc, c);
                end else if (term) begin
                    rec.range_low  = OUT_BITS'(acc);
                    rec.range_high = OUT_BITS'(acc);
                    phase = PH_BEGIN_NUMBER;
                    emit  = 1'b1;
                end else if (c == CH_DASH) begin
                    start = acc;
                    phase = PH_BEGIN_INTERVAL;
                end else begin
                    rec.error_code = ERR_BAD_NUMBER;
                    emit = 1'b1;
                end
            end
            PH_BEGIN_INTERVAL: begin
                if (digit) begin
                    acc   = VALUE_BITS'(c - CH_ZERO);
                    phase = PH_INTERVAL;
                end else begin
                    rec.error_code = ERR_NEED_DIGIT;
                    emit = 1'b1;
                end
            end
            PH_INTERVAL: begin
                if (digit) begin
                    acc = decimal_shift(acc, c);
                end else if (term) begin
                    rec.range_low  = OUT_BITS'(start);
                    rec.range_high = OUT_BITS'(acc);
                    phase = PH_BEGIN_NUMBER;
                    emit  = 1'b1;
                end else if (c == CH_DASH) begin
                    rec.error_code = ERR_SECOND_DASH;
                    emit = 1'b1;
                end else begin
                    rec.error_code = ERR_BAD_INTERVAL;
                    emit = 1'b1;
                end
            end
            default: phase = PH_HALTED;
        endcase
        if (emit) begin
            if (rec.error_code != ERR_OK) begin
                rec.error_position = pos;
                phase = PH_HALTED;
            end
            pending_records.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase = PH_BEGIN_NUMBER;
            acc   = '0;
            start = '0;
            pos   = '0;
            pending_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_records.size() == 0) begin
                    report_mismatch("record with none pending, range_low",
                                    32'(i_range_low), 32'(0));
                end else begin
                    want = pending_records.pop_front();
                    check_field("range_low", 32'(i_range_low), 32'(want.range_low));
                    check_field("range_high", 32'(i_range_high), 32'(want.range_high));
                    check_field("error_code", 32'(i_error_code), 32'(want.error_code));
                    check_field("error_position", 32'(i_error_position),
                                32'(want.error_position));
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_word(i_char_code);
            end
        end
        o_pending_count <= pending_records.size();
        o_fail_count    <= fails;
    end

endmodule

// File: tb/sv/tb_number_range_list_parser.sv
// Testbench top for the number range list parser: clock, reset, character
// stimulus, output stalls and the verdict. Depends on nrlp_pkg, the block
// and nrlp_range_checker.
module tb_number_range_list_parser;
    import nrlp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_CHARS = 950;

    typedef enum int {
        BAD_LEAD_COMMA,
        BAD_LEAD_CHAR,
        BAD_AFTER_DASH,
        BAD_IN_NUMBER,
        BAD_SECOND_DASH,
        BAD_IN_INTERVAL
    } t_fault;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CHAR_BITS-1:0] i_char_code = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUT_BITS-1:0]  o_range_low;
    logic [OUT_BITS-1:0]  o_range_high;
    logic [CODE_BITS-1:0] o_error_code;
    logic [POS_BITS-1:0]  o_error_position;
    int                   fail_count;
    int                   pending_count;

    int     cycles;
    int     chars_sent;
    int     entries_sent;
    int     burst_left;
    int     stall_left;
    int     stall_mode;
    int     stall_tick;
    t_fault fault;

    always #4 i_clk = ~i_clk;

    number_range_list_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_range_low     (o_range_low),
        .o_range_high    (o_range_high),
        .o_error_code    (o_error_code),
        .o_error_position(o_error_position)
    );

    nrlp_range_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_range_low     (o_range_low),
        .i_range_high    (o_range_high),
        .i_error_code    (o_error_code),
        .i_error_position(o_error_position),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls: stretches of always-ready, coin-flip, mostly-stalled, fixed pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 1);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_tick % 5 != 2);
        endcase
    end

    task automatic send_char(input logic [CHAR_BITS-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_number(input longint unsigned v, input int lead_zeros);
        logic [CHAR_BITS-1:0] digs[$];
        if (v == 0) begin
            digs.push_front(CH_ZERO);
        end
        while (v > 0) begin
            digs.push_front(CH_ZERO + CHAR_BITS'(v % 10));
            v = v / 10;
        end
        repeat (lead_zeros) send_char(CH_ZERO);
        foreach (digs[i]) send_char(digs[i]);
    endtask

    task automatic send_entry(input longint unsigned lo, input longint unsigned hi,
                              input logic interval, input logic [CHAR_BITS-1:0] term);
        send_number(lo, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        if (interval) begin
            send_char(CH_DASH);
            send_number(hi, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        end
        send_char(term);
        entries_sent++;
    endtask

    function automatic longint unsigned pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(0, 20));
            4, 5:       return 64'($urandom_range(0, 999));
            6:          return 64'($urandom_range(0, 65535));
            7:          return 64'($urandom_range(65530, 65535));
            8:          return 64'($urandom_range(65536, 99999));
            default:    return 64'($urandom);
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_term();
        case ($urandom_range(0, 7))
            6:       return CH_NEWLINE;
            7:       return CH_NUL;
            default: return CH_COMMA;
        endcase
    endfunction

    // any byte that is not a digit, a terminator or a dash
    function automatic logic [CHAR_BITS-1:0] pick_bad();
        logic [CHAR_BITS-1:0] c;
        c = CHAR_BITS'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COMMA || c == CH_NEWLINE ||
               c == CH_NUL || c == CH_DASH) begin
            c = CHAR_BITS'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic drain_records();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic                 paused;
        longint unsigned      lo;
        longint unsigned      hi;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ignored terminators at start, extremes, saturation, reversed interval
        send_char(CH_NEWLINE);
        send_char(CH_NUL);
        send_number(0, 0);
        send_char(CH_COMMA);
        send_number(65535, 0);
        send_char(CH_COMMA);
        send_number(99999, 0);
        send_char(CH_NEWLINE);
        send_entry(9, 0, 1'b1, CH_COMMA);
        send_entry(0, 65535, 1'b1, CH_NUL);

        paused = 1'b0;
        while (chars_sent < RANDOM_CHARS) begin
            if (!paused && chars_sent > RANDOM_CHARS / 2) begin
                drain_records();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                send_char(($urandom_range(0, 1) == 0) ? CH_NEWLINE : CH_NUL);
            end
            lo = pick_value();
            case ($urandom_range(0, 3))
                0:       hi = lo;
                1:       hi = pick_value();
                default: hi = lo + 64'($urandom_range(0, 50));
            endcase
            send_entry(lo, hi, $urandom_range(0, 2) != 0, pick_term());
        end

        fault = t_fault'($urandom_range(0, 5));
        case (fault)
            BAD_LEAD_COMMA: send_char(CH_COMMA);
            BAD_LEAD_CHAR: send_char(($urandom_range(0, 3) == 0) ? CH_DASH : pick_bad());
            BAD_AFTER_DASH: begin
                send_number(pick_value(), 0);
                send_char(CH_DASH);
                send_char(($urandom_range(0, 1) == 0) ? pick_term() : pick_bad());
            end
            BAD_IN_NUMBER: begin
                send_number(pick_value(), 0);
                send_char(pick_bad());
            end
            BAD_SECOND_DASH: begin
                send_number(pick_value(), 0);
                send_char(CH_DASH);
                send_number(pick_value(), 0);
                send_char(CH_DASH);
            end
            default: begin
                send_number(pick_value(), 0);
                send_char(CH_DASH);
                send_number(pick_value(), 0);
                send_char(pick_bad());
            end
        endcase

        // halted: everything below is dropped
        repeat (200) send_char(CHAR_BITS'($urandom_range(0, 255)));

        drain_records();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d words sent, %0d entries closed, final fault %s",
                 chars_sent, entries_sent, fault.name());
        $display("summary: saturating and reversed entries, stalls, then dropped words");
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
